@@ hdl/hrbp_pkg.sv @@
package hrbp_pkg;

	typedef struct packed {
		logic       command;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [2:0] byte_class;
		logic       header_begins;
		logic [7:0] byte_echo;
		logic [7:0] version_major;
		logic [7:0] version_minor;
		logic       method_is_get;
	} out_item_t;

	// per-byte character classes shared by the parser
	typedef struct packed {
		logic ctl;
		logic token;
		logic digit;
		logic sp;
		logic ht;
		logic cr;
		logic lf;
		logic colon;
	} chr_flags_t;

	typedef enum logic [22:0] {
		ST_MSTART    = 23'h000001,
		ST_METHOD    = 23'h000002,
		ST_URI_START = 23'h000004,
		ST_URI       = 23'h000008,
		ST_VH        = 23'h000010,
		ST_VT1       = 23'h000020,
		ST_VT2       = 23'h000040,
		ST_VP        = 23'h000080,
		ST_VSLASH    = 23'h000100,
		ST_MAJ_START = 23'h000200,
		ST_MAJ       = 23'h000400,
		ST_MIN_START = 23'h000800,
		ST_MIN       = 23'h001000,
		ST_NL1       = 23'h002000,
		ST_HLS       = 23'h004000,
		ST_LWS       = 23'h008000,
		ST_HNAME     = 23'h010000,
		ST_SPACE     = 23'h020000,
		ST_HVAL      = 23'h040000,
		ST_NL2       = 23'h080000,
		ST_NL3       = 23'h100000,
		ST_BODY      = 23'h200000,
		ST_HALT      = 23'h400000
	} parse_state_t;

	localparam logic [1:0] STATUS_MORE = 2'd0;
	localparam logic [1:0] STATUS_DONE = 2'd1;
	localparam logic [1:0] STATUS_BAD  = 2'd2;

	localparam logic [2:0] CLS_DELIM  = 3'd0;
	localparam logic [2:0] CLS_METHOD = 3'd1;
	localparam logic [2:0] CLS_URI    = 3'd2;
	localparam logic [2:0] CLS_HNAME  = 3'd3;
	localparam logic [2:0] CLS_HVAL   = 3'd4;
	localparam logic [2:0] CLS_BODY   = 3'd5;

	localparam logic [7:0] CH_HT    = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_DEL   = 8'h7F;
	localparam logic [7:0] CH_LAST_CTL = 8'h1F;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	localparam logic [1:0] GET_LEN  = 2'd3;
	localparam logic [3:0] NAME_LEN = 4'd14;

	function automatic logic [7:0] get_char(input logic [1:0] idx);
		logic [7:0] ch;
		case (idx)
			2'd0: ch = 8'h47;
			2'd1: ch = 8'h45;
			2'd2: ch = 8'h54;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// lower-case content-length
	function automatic logic [7:0] name_char(input logic [3:0] idx);
		logic [7:0] ch;
		case (idx)
			4'd0:  ch = 8'h63;
			4'd1:  ch = 8'h6F;
			4'd2:  ch = 8'h6E;
			4'd3:  ch = 8'h74;
			4'd4:  ch = 8'h65;
			4'd5:  ch = 8'h6E;
			4'd6:  ch = 8'h74;
			4'd7:  ch = 8'h2D;
			4'd8:  ch = 8'h6C;
			4'd9:  ch = 8'h65;
			4'd10: ch = 8'h6E;
			4'd11: ch = 8'h67;
			4'd12: ch = 8'h74;
			4'd13: ch = 8'h68;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

@@ hdl/hrbp_classify.sv @@
module hrbp_classify
	import hrbp_pkg::*;
(
	input  logic [7:0] ch,
	output chr_flags_t flags
);

	logic sep;

	always_comb begin
		sep = ch inside {8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C,
			8'h22, 8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D, CH_SP, CH_HT};
		flags.ctl   = (ch <= CH_LAST_CTL) || (ch == CH_DEL);
		flags.token = !ch[7] && !flags.ctl && !sep;
		flags.digit = ch inside {[8'h30:8'h39]};
		flags.sp    = (ch == CH_SP);
		flags.ht    = (ch == CH_HT);
		flags.cr    = (ch == CH_CR);
		flags.lf    = (ch == CH_LF);
		flags.colon = (ch == CH_COLON);
	end

endmodule

@@ hdl/hrbp_dec_acc.sv @@
module hrbp_dec_acc #(
	parameter int BITS = 8
) (
	input  logic [BITS-1:0] acc,
	input  logic [3:0]      digit,
	output logic [BITS-1:0] sum
);

	localparam int W = BITS + 4;

	logic [W-1:0] ext;
	logic [W-1:0] prod;

	// acc * 10 + digit, clamped to all ones
	always_comb begin
		ext  = W'(acc);
		prod = (ext << 3) + (ext << 1) + W'(digit);
		sum  = (|prod[W-1:BITS]) ? {BITS{1'b1}} : prod[BITS-1:0];
	end

endmodule

@@ hdl/hrbp_engine.sv @@
module hrbp_engine
	import hrbp_pkg::*;
#(
	parameter int LENGTH_BITS  = 24,
	parameter int VERSION_BITS = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  in_item_t  item,
	output out_item_t result
);

	parse_state_t state_q, state_d;
	logic [1:0] get_cnt_q, get_cnt_d;
	logic get_miss_q, get_miss_d;
	logic hdr_seen_q, hdr_seen_d;
	logic [VERSION_BITS-1:0] major_q, major_d;
	logic [VERSION_BITS-1:0] minor_q, minor_d;
	logic [3:0] name_idx_q, name_idx_d;
	logic name_miss_q, name_miss_d;
	logic len_active_q, len_active_d;
	logic [LENGTH_BITS-1:0] body_len_q, body_len_d;
	logic [LENGTH_BITS-1:0] body_cnt_q, body_cnt_d;

	chr_flags_t fl;
	logic [7:0] ch;
	logic [7:0] lc;
	logic [VERSION_BITS-1:0] major_acc;
	logic [VERSION_BITS-1:0] minor_acc;
	logic [LENGTH_BITS-1:0] len_acc;
	logic [LENGTH_BITS-1:0] cnt_inc;
	logic [VERSION_BITS+7:0] major_ext;
	logic [VERSION_BITS+7:0] minor_ext;
	logic get_hit;
	logic name_hit;
	logic bad;
	logic [1:0] status;
	logic [2:0] cls;
	logic hb;

	assign ch = item.data_byte;
	assign lc = (ch inside {[8'h41:8'h5A]}) ? ch + CASE_OFFSET : ch;

	hrbp_classify u_classify (
		.ch    (ch),
		.flags (fl)
	);

	hrbp_dec_acc #(.BITS(VERSION_BITS)) u_major_acc (
		.acc   (major_q),
		.digit (ch[3:0]),
		.sum   (major_acc)
	);

	hrbp_dec_acc #(.BITS(VERSION_BITS)) u_minor_acc (
		.acc   (minor_q),
		.digit (ch[3:0]),
		.sum   (minor_acc)
	);

	hrbp_dec_acc #(.BITS(LENGTH_BITS)) u_len_acc (
		.acc   (body_len_q),
		.digit (ch[3:0]),
		.sum   (len_acc)
	);

	assign cnt_inc  = body_cnt_q + LENGTH_BITS'(1);
	assign get_hit  = (get_cnt_q != GET_LEN) && (ch == get_char(get_cnt_q));
	assign name_hit = (name_idx_q < NAME_LEN) && (lc == name_char(name_idx_q));

	always_comb begin
		state_d      = state_q;
		get_cnt_d    = get_cnt_q;
		get_miss_d   = get_miss_q;
		hdr_seen_d   = hdr_seen_q;
		major_d      = major_q;
		minor_d      = minor_q;
		name_idx_d   = name_idx_q;
		name_miss_d  = name_miss_q;
		len_active_d = len_active_q;
		body_len_d   = body_len_q;
		body_cnt_d   = body_cnt_q;
		bad    = 1'b0;
		status = STATUS_MORE;
		cls    = CLS_DELIM;
		hb     = 1'b0;

		if (item.command) begin
			state_d      = ST_MSTART;
			get_cnt_d    = '0;
			get_miss_d   = 1'b0;
			hdr_seen_d   = 1'b0;
			major_d      = '0;
			minor_d      = '0;
			name_idx_d   = '0;
			name_miss_d  = 1'b0;
			len_active_d = 1'b0;
			body_len_d   = '0;
			body_cnt_d   = '0;
		end else begin
			case (state_q)
				ST_MSTART, ST_METHOD: begin
					if (state_q == ST_METHOD && fl.sp) begin
						state_d = ST_URI_START;
					end else if (fl.token) begin
						state_d = ST_METHOD;
						cls = CLS_METHOD;
						if (get_hit) get_cnt_d = get_cnt_q + 2'd1;
						else get_miss_d = 1'b1;
					end else bad = 1'b1;
				end
				ST_URI_START: begin
					if (fl.ctl) bad = 1'b1;
					else begin
						state_d = ST_URI;
						cls = CLS_URI;
					end
				end
				ST_URI: begin
					if (fl.sp) state_d = ST_VH;
					else if (fl.ctl) bad = 1'b1;
					else cls = CLS_URI;
				end
				ST_VH: begin
					if (ch == CH_H) state_d = ST_VT1;
					else bad = 1'b1;
				end
				ST_VT1: begin
					if (ch == CH_T) state_d = ST_VT2;
					else bad = 1'b1;
				end
				ST_VT2: begin
					if (ch == CH_T) state_d = ST_VP;
					else bad = 1'b1;
				end
				ST_VP: begin
					if (ch == CH_P) state_d = ST_VSLASH;
					else bad = 1'b1;
				end
				ST_VSLASH: begin
					if (ch == CH_SLASH) begin
						major_d = '0;
						minor_d = '0;
						state_d = ST_MAJ_START;
					end else bad = 1'b1;
				end
				ST_MAJ_START: begin
					if (fl.digit) begin
						major_d = major_acc;
						state_d = ST_MAJ;
					end else bad = 1'b1;
				end
				ST_MAJ: begin
					if (ch == CH_DOT) state_d = ST_MIN_START;
					else if (fl.digit) major_d = major_acc;
					else bad = 1'b1;
				end
				ST_MIN_START: begin
					if (fl.digit) begin
						minor_d = minor_acc;
						state_d = ST_MIN;
					end else bad = 1'b1;
				end
				ST_MIN: begin
					if (fl.cr) state_d = ST_NL1;
					else if (fl.digit) minor_d = minor_acc;
					else bad = 1'b1;
				end
				ST_NL1: begin
					if (fl.lf) state_d = ST_HLS;
					else bad = 1'b1;
				end
				ST_HLS: begin
					if (fl.cr) state_d = ST_NL3;
					else if (hdr_seen_q && (fl.sp || fl.ht)) state_d = ST_LWS;
					else if (fl.token) begin
						hb = 1'b1;
						cls = CLS_HNAME;
						hdr_seen_d = 1'b1;
						len_active_d = 1'b0;
						// name match restarts at the first character
						if (lc == name_char(4'd0)) begin
							name_idx_d = 4'd1;
							name_miss_d = 1'b0;
						end else begin
							name_idx_d = 4'd0;
							name_miss_d = 1'b1;
						end
						state_d = ST_HNAME;
					end else bad = 1'b1;
				end
				ST_LWS, ST_HVAL: begin
					if (fl.cr) state_d = ST_NL2;
					else if (state_q == ST_LWS && (fl.sp || fl.ht)) begin
					end else if (fl.ctl) bad = 1'b1;
					else begin
						state_d = ST_HVAL;
						cls = CLS_HVAL;
						if (len_active_q) begin
							if (fl.digit) body_len_d = len_acc;
							else if (!fl.sp && !fl.ht) len_active_d = 1'b0;
						end
					end
				end
				ST_HNAME: begin
					if (fl.colon) begin
						state_d = ST_SPACE;
						if (!name_miss_q && name_idx_q == NAME_LEN) begin
							len_active_d = 1'b1;
							body_len_d = '0;
						end
					end else if (fl.token) begin
						cls = CLS_HNAME;
						if (!name_miss_q) begin
							if (name_hit) name_idx_d = name_idx_q + 4'd1;
							else name_miss_d = 1'b1;
						end
					end else bad = 1'b1;
				end
				ST_SPACE: begin
					if (fl.sp) state_d = ST_HVAL;
					else bad = 1'b1;
				end
				ST_NL2: begin
					if (fl.lf) state_d = ST_HLS;
					else bad = 1'b1;
				end
				ST_NL3: begin
					if (!fl.lf) bad = 1'b1;
					else if ((get_cnt_q == GET_LEN && !get_miss_q) || body_len_q == '0) begin
						status = STATUS_DONE;
						state_d = ST_HALT;
					end else begin
						body_cnt_d = '0;
						state_d = ST_BODY;
					end
				end
				ST_BODY: begin
					cls = CLS_BODY;
					body_cnt_d = cnt_inc;
					if (cnt_inc >= body_len_q) begin
						status = STATUS_DONE;
						state_d = ST_HALT;
					end
				end
				default: bad = 1'b1;
			endcase

			if (bad) begin
				state_d = ST_HALT;
				status = STATUS_BAD;
				cls = CLS_DELIM;
				hb = 1'b0;
			end
		end
	end

	assign major_ext = {8'd0, major_d};
	assign minor_ext = {8'd0, minor_d};

	always_comb begin
		result.status        = status;
		result.byte_class    = cls;
		result.header_begins = hb;
		result.byte_echo     = ch;
		result.version_major = major_ext[7:0];
		result.version_minor = minor_ext[7:0];
		result.method_is_get = (get_cnt_d == GET_LEN) && !get_miss_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_MSTART;
			get_cnt_q    <= '0;
			get_miss_q   <= 1'b0;
			hdr_seen_q   <= 1'b0;
			major_q      <= '0;
			minor_q      <= '0;
			name_idx_q   <= '0;
			name_miss_q  <= 1'b0;
			len_active_q <= 1'b0;
			body_len_q   <= '0;
			body_cnt_q   <= '0;
		end else if (step) begin
			state_q      <= state_d;
			get_cnt_q    <= get_cnt_d;
			get_miss_q   <= get_miss_d;
			hdr_seen_q   <= hdr_seen_d;
			major_q      <= major_d;
			minor_q      <= minor_d;
			name_idx_q   <= name_idx_d;
			name_miss_q  <= name_miss_d;
			len_active_q <= len_active_d;
			body_len_q   <= body_len_d;
			body_cnt_q   <= body_cnt_d;
		end
	end

	// a finished or rejected request parks the parser
	assert property (@(posedge clk) disable iff (!arst_n)
		step && !item.command && result.status != STATUS_MORE |=> state_q == ST_HALT)
		else $error("parser not halted after final status");

	// once halted, only a restart leaves
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_HALT && !(step && item.command) |=> state_q == ST_HALT)
		else $error("parser left halt without restart");

	assert property (@(posedge clk) disable iff (!arst_n)
		result.header_begins |-> result.byte_class == CLS_HNAME && state_q == ST_HLS)
		else $error("header start outside header line start");

endmodule

@@ hdl/http_request_byte_parser.sv @@
// HTTP/1.1 request byte parser.
// Request channel: req_valid/req_ready carry req_item, one byte per item with a
// command bit; command 1 restarts the parser at the method token and yields no
// result, command 0 feeds data_byte through the parser.
// Response channel: rsp_valid/rsp_ready carry rsp_item, one item per data byte:
// status (need more, complete, malformed), byte class, header start flag, the
// byte itself, the parsed version and whether the method is exactly GET.
// A byte accepted into the input register is parsed from there; its result is
// registered in the output register together with the parser state update.
// Throughput: one item per cycle while results are taken; the only loop is the
// parser state update between the input register and the result register.
// Reset clears the parser to the method start and empties both registers.
// When the receiver stalls, the result waits in the output register, the next
// byte waits in the input register, and req_ready drops until the result is
// taken. After completion or a malformed byte every data byte answers
// malformed until a restart item arrives.
module http_request_byte_parser
	import hrbp_pkg::*;
#(
	parameter int LENGTH_BITS  = 24,
	parameter int VERSION_BITS = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  in_item_t  req_item,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output out_item_t rsp_item
);

	logic      valid_s1;
	in_item_t  item_s1;
	logic      advance;
	out_item_t result;
	logic      rsp_valid_q;
	out_item_t rsp_item_q;

	// a restart item never needs room in the result register
	assign advance   = valid_s1 && (item_s1.command || !rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_s1 <= req_item;
		end
	end

	hrbp_engine #(
		.LENGTH_BITS  (LENGTH_BITS),
		.VERSION_BITS (VERSION_BITS)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance && !item_s1.command) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && !item_s1.command) begin
			rsp_item_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_item_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !item_s1.command && rsp_valid_q && !rsp_ready |-> !req_ready)
		else $error("byte taken while both registers are blocked");

	assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.command && !rsp_ready |=> rsp_valid_q == $past(rsp_valid_q))
		else $error("restart item changed the response register");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_item_q.status == STATUS_BAD |->
			rsp_item_q.byte_class == CLS_DELIM && !rsp_item_q.header_begins)
		else $error("malformed item carries a byte class");

endmodule

@@ verif/tb_http_request_byte_parser.sv @@
`timescale 1ns / 100ps

module tb_http_request_byte_parser;
	import hrbp_pkg::*;

	// tracks the parser byte by byte and holds the results still owed by the block
	class request_tracker;
		out_item_t    expected_results[$];
		int           errors;
		int           n_checked;
		int           n_done;
		int           n_bad;
		parse_state_t pstate;
		logic [1:0]   get_cnt;
		logic         get_miss;
		logic         hdr_seen;
		logic [7:0]   major;
		logic [7:0]   minor;
		logic [3:0]   name_idx;
		logic         name_miss;
		logic         in_len;
		logic [23:0]  body_len;
		logic [23:0]  body_cnt;
		string        get_word = "GET";
		string        len_word = "content-length";

		function new();
			clear_state();
		endfunction

		function void clear_state();
			pstate    = ST_MSTART;
			get_cnt   = '0;
			get_miss  = 1'b0;
			hdr_seen  = 1'b0;
			major     = '0;
			minor     = '0;
			name_idx  = '0;
			name_miss = 1'b0;
			in_len    = 1'b0;
			body_len  = '0;
			body_cnt  = '0;
		endfunction

		static function bit is_ctl(logic [7:0] c);
			return c <= CH_LAST_CTL || c == CH_DEL;
		endfunction

		static function bit is_num(logic [7:0] c);
			return c >= "0" && c <= "9";
		endfunction

		static function bit is_token(logic [7:0] c);
			string seps;
			bit    sep;
			seps = "()<>@,;:\\\"/[]?={} \t";
			sep = 1'b0;
			for (int i = 0; i < seps.len(); i++)
				if (seps[i] == c)
					sep = 1'b1;
			return c < 8'h80 && !is_ctl(c) && !sep;
		endfunction

		// decimal accumulate, clamped to an all-ones value of the given width
		function logic [31:0] dec_acc(logic [31:0] v, logic [7:0] c, int bits);
			longint unsigned r;
			longint unsigned maxv;
			maxv = (64'd1 << bits) - 1;
			r = v * 64'd10 + (c - "0");
			return 32'((r > maxv) ? maxv : r);
		endfunction

		function void track_get(logic [7:0] c);
			if (get_cnt < GET_LEN && c == get_word[get_cnt]) begin
				get_cnt++;
			end else begin
				get_miss = 1'b1;
			end
		endfunction

		function void track_name(logic [7:0] c);
			logic [7:0] lc;
			lc = (c >= "A" && c <= "Z") ? c + CASE_OFFSET : c;
			if (name_miss)
				return;
			if (name_idx < NAME_LEN && lc == len_word[name_idx]) begin
				name_idx++;
			end else begin
				name_miss = 1'b1;
			end
		endfunction

		function void track_value(logic [7:0] c);
			if (!in_len)
				return;
			if (is_num(c)) begin
				body_len = 24'(dec_acc(32'(body_len), c, 24));
			end else if (c != CH_SP && c != CH_HT) begin
				in_len = 1'b0;
			end
		endfunction

		function void parse_byte(in_item_t it);
			logic [7:0] c;
			logic [1:0] status;
			logic [2:0] cls;
			logic       hb;
			logic       bad;
			out_item_t  r;
			if (it.command) begin
				clear_state();
				return;
			end
			c = it.data_byte;
			status = STATUS_MORE;
			cls = CLS_DELIM;
			hb = 1'b0;
			bad = 1'b0;
			case (pstate)
				ST_MSTART: begin
					if (is_token(c)) begin
						pstate = ST_METHOD;
						cls = CLS_METHOD;
						track_get(c);
					end else bad = 1'b1;
				end
				ST_METHOD: begin
					if (c == CH_SP) pstate = ST_URI_START;
					else if (is_token(c)) begin
						cls = CLS_METHOD;
						track_get(c);
					end else bad = 1'b1;
				end
				ST_URI_START: begin
					if (is_ctl(c)) bad = 1'b1;
					else begin
						pstate = ST_URI;
						cls = CLS_URI;
					end
				end
				ST_URI: begin
					if (c == CH_SP) pstate = ST_VH;
					else if (is_ctl(c)) bad = 1'b1;
					else cls = CLS_URI;
				end
				ST_VH: if (c == CH_H) pstate = ST_VT1; else bad = 1'b1;
				ST_VT1: if (c == CH_T) pstate = ST_VT2; else bad = 1'b1;
				ST_VT2: if (c == CH_T) pstate = ST_VP; else bad = 1'b1;
				ST_VP: if (c == CH_P) pstate = ST_VSLASH; else bad = 1'b1;
				ST_VSLASH: begin
					if (c == CH_SLASH) begin
						major = '0;
						minor = '0;
						pstate = ST_MAJ_START;
					end else bad = 1'b1;
				end
				ST_MAJ_START: begin
					if (is_num(c)) begin
						major = 8'(dec_acc(32'(major), c, 8));
						pstate = ST_MAJ;
					end else bad = 1'b1;
				end
				ST_MAJ: begin
					if (c == CH_DOT) pstate = ST_MIN_START;
					else if (is_num(c)) major = 8'(dec_acc(32'(major), c, 8));
					else bad = 1'b1;
				end
				ST_MIN_START: begin
					if (is_num(c)) begin
						minor = 8'(dec_acc(32'(minor), c, 8));
						pstate = ST_MIN;
					end else bad = 1'b1;
				end
				ST_MIN: begin
					if (c == CH_CR) pstate = ST_NL1;
					else if (is_num(c)) minor = 8'(dec_acc(32'(minor), c, 8));
					else bad = 1'b1;
				end
				ST_NL1: if (c == CH_LF) pstate = ST_HLS; else bad = 1'b1;
				ST_HLS: begin
					if (c == CH_CR) pstate = ST_NL3;
					else if (hdr_seen && (c == CH_SP || c == CH_HT)) pstate = ST_LWS;
					else if (is_token(c)) begin
						hb = 1'b1;
						cls = CLS_HNAME;
						hdr_seen = 1'b1;
						in_len = 1'b0;
						name_idx = '0;
						name_miss = 1'b0;
						track_name(c);
						pstate = ST_HNAME;
					end else bad = 1'b1;
				end
				ST_LWS: begin
					if (c == CH_CR) pstate = ST_NL2;
					else if (c == CH_SP || c == CH_HT) begin
					end else if (is_ctl(c)) bad = 1'b1;
					else begin
						pstate = ST_HVAL;
						cls = CLS_HVAL;
						track_value(c);
					end
				end
				ST_HNAME: begin
					if (c == CH_COLON) begin
						pstate = ST_SPACE;
						if (!name_miss && name_idx == NAME_LEN) begin
							in_len = 1'b1;
							body_len = '0;
						end
					end else if (is_token(c)) begin
						cls = CLS_HNAME;
						track_name(c);
					end else bad = 1'b1;
				end
				ST_SPACE: if (c == CH_SP) pstate = ST_HVAL; else bad = 1'b1;
				ST_HVAL: begin
					if (c == CH_CR) pstate = ST_NL2;
					else if (is_ctl(c)) bad = 1'b1;
					else begin
						cls = CLS_HVAL;
						track_value(c);
					end
				end
				ST_NL2: if (c == CH_LF) pstate = ST_HLS; else bad = 1'b1;
				ST_NL3: begin
					if (c != CH_LF) bad = 1'b1;
					else if ((get_cnt == GET_LEN && !get_miss) || body_len == '0) begin
						status = STATUS_DONE;
						pstate = ST_HALT;
					end else begin
						body_cnt = '0;
						pstate = ST_BODY;
					end
				end
				ST_BODY: begin
					cls = CLS_BODY;
					body_cnt = body_cnt + 24'd1;
					if (body_cnt >= body_len) begin
						status = STATUS_DONE;
						pstate = ST_HALT;
					end
				end
				default: bad = 1'b1;
			endcase
			if (bad) begin
				pstate = ST_HALT;
				status = STATUS_BAD;
				cls = CLS_DELIM;
				hb = 1'b0;
			end
			if (status == STATUS_DONE) n_done++;
			if (status == STATUS_BAD) n_bad++;
			r.status        = status;
			r.byte_class    = cls;
			r.header_begins = hb;
			r.byte_echo     = c;
			r.version_major = major;
			r.version_minor = minor;
			r.method_is_get = (get_cnt == GET_LEN && !get_miss);
			expected_results = {expected_results, r};
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (want !== got) begin
				if (errors < 40)
					$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %p", $time, got);
				errors++;
				return;
			end
			want = expected_results.pop_front();
			n_checked++;
			compare_field("status", 8'(want.status), 8'(got.status));
			compare_field("byte_class", 8'(want.byte_class), 8'(got.byte_class));
			compare_field("header_begins", 8'(want.header_begins), 8'(got.header_begins));
			compare_field("byte_echo", want.byte_echo, got.byte_echo);
			compare_field("version_major", want.version_major, got.version_major);
			compare_field("version_minor", want.version_minor, got.version_minor);
			compare_field("method_is_get", 8'(want.method_is_get), 8'(got.method_is_get));
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	in_item_t  req_item = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	out_item_t rsp_item;

	request_tracker sb = new();
	logic [7:0]     byte_q[$];
	int             n_sent = 0;
	bit             calm = 1'b0;
	bit             long_hold_done = 1'b0;
	int             stall_left = 0;

	http_request_byte_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_item  (req_item),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_item  (rsp_item)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	task automatic send_item(logic cmd, logic [7:0] b);
		in_item_t it;
		it.command = cmd;
		it.data_byte = b;
		if (!calm && $urandom_range(0, 9) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_item <= it;
		do @(posedge clk); while (!req_ready);
		sb.parse_byte(it);
		n_sent++;
		if (n_sent >= 560)
			calm = 1'b1;
	endtask

	task automatic send_queue();
		foreach (byte_q[i])
			send_item(1'b0, byte_q[i]);
	endtask

	function automatic void add_byte(logic [7:0] b);
		byte_q = {byte_q, b};
	endfunction

	function automatic void push_str(string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endfunction

	function automatic void push_crlf();
		add_byte(CH_CR);
		add_byte(CH_LF);
	endfunction

	function automatic logic [7:0] token_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(33, 126)); while (!request_tracker::is_token(b));
		return b;
	endfunction

	// any byte that is not a control byte, space allowed only where asked
	function automatic logic [7:0] text_byte(bit allow_sp);
		logic [7:0] b;
		do b = 8'($urandom_range(32, 255)); while (b == CH_DEL || (!allow_sp && b == CH_SP));
		return b;
	endfunction

	function automatic logic [7:0] digit_byte();
		return 8'($urandom_range(8'h30, 8'h39));
	endfunction

	// one request, well formed most of the time, then maybe damaged
	function automatic void build_request();
		int         pick;
		int         cl_len;
		bit         plain_get;
		string      w;
		logic [7:0] b;
		byte_q.delete();
		cl_len = 0;
		pick = $urandom_range(0, 7);
		plain_get = (pick < 4);
		case (pick)
			0, 1, 2, 3: push_str("GET");
			4: push_str("POST");
			5: push_str("GETS");
			6: push_str("GE");
			default: repeat ($urandom_range(1, 5)) add_byte(token_byte());
		endcase
		add_byte(CH_SP);
		// a second space is taken as the first uri byte
		if ($urandom_range(0, 7) == 0)
			add_byte(CH_SP);
		repeat ($urandom_range(1, 6)) add_byte(text_byte(1'b0));
		add_byte(CH_SP);
		push_str("HTTP/");
		if ($urandom_range(0, 1)) begin
			push_str("1.1");
		end else begin
			repeat ($urandom_range(1, 4)) add_byte(digit_byte());
			add_byte(CH_DOT);
			repeat ($urandom_range(1, 4)) add_byte(digit_byte());
		end
		push_crlf();
		repeat ($urandom_range(0, 3)) begin
			if ($urandom_range(0, 2) == 0) begin
				w = "content-length";
				for (int i = 0; i < w.len(); i++) begin
					b = w[i];
					if (b >= "a" && b <= "z" && $urandom_range(0, 1))
						b = b - CASE_OFFSET;
					add_byte(b);
				end
				add_byte(CH_COLON);
				add_byte(CH_SP);
				if ($urandom_range(0, 3) == 0)
					add_byte($urandom_range(0, 1) ? CH_SP : CH_HT);
				// a huge length only where the method never reads a body
				if (plain_get && $urandom_range(0, 2) == 0) begin
					push_str("99999999");
				end else begin
					cl_len = $urandom_range(0, 6);
					push_str($sformatf("%0d", cl_len));
				end
			end else begin
				repeat ($urandom_range(1, 6)) add_byte(token_byte());
				add_byte(CH_COLON);
				add_byte(CH_SP);
				repeat ($urandom_range(0, 6)) add_byte(text_byte(1'b1));
			end
			push_crlf();
			// folded continuation, led by a letter so a length value is not extended
			if ($urandom_range(0, 4) == 0) begin
				add_byte($urandom_range(0, 1) ? CH_SP : CH_HT);
				add_byte(8'($urandom_range(8'h61, 8'h7A)));
				repeat ($urandom_range(0, 3)) add_byte(text_byte(1'b1));
				push_crlf();
			end
		end
		push_crlf();
		if (!plain_get)
			repeat (cl_len) add_byte(8'($urandom_range(0, 255)));
		if ($urandom_range(0, 5) == 0)
			byte_q[$urandom_range(0, byte_q.size() - 1)] = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 9) == 0) begin
			pick = $urandom_range(1, byte_q.size());
			while (byte_q.size() > pick)
				void'(byte_q.pop_back());
		end
	endfunction

	// result side: random stalls, one long hold to back the block up
	initial begin
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready)
				sb.check_result(rsp_item);
			if (!long_hold_done && sb.n_checked >= 80) begin
				long_hold_done = 1'b1;
				stall_left = 80;
			end
			if (calm)
				stall_left = 0;
			if (stall_left > 0) begin
				stall_left--;
				rsp_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 19) - 1;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// simple get, then halted bytes, then a bad first method byte
		send_item(1'b1, 8'hFF);
		byte_q.delete();
		push_str("GET / HTTP/1.1");
		push_crlf();
		push_crlf();
		send_queue();
		send_item(1'b0, 8'hFF);
		send_item(1'b0, 8'h00);
		send_item(1'b1, 8'h00);
		send_item(1'b0, 8'h00);
		send_item(1'b1, 8'h5A);

		while (n_sent < 650) begin
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 12))
					send_item($urandom_range(0, 15) == 0, 8'($urandom_range(0, 255)));
			end else begin
				send_item(1'b1, 8'($urandom_range(0, 255)));
				build_request();
				send_queue();
			end
		end
		req_valid <= 1'b0;

		while (sb.expected_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("run covered %0d items and %0d results: %0d requests complete, %0d malformed",
			n_sent, sb.n_checked, sb.n_done, sb.n_bad);
		if (sb.errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
